>>> rtl/dfp_pkg.sv
// Shared types and constants of the deadline frame pacer.
// Used by dfp_ctrl, dfp_datapath and deadline_frame_pacer; depends on nothing.
package dfp_pkg;

    localparam int LAG_W = 36;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PACING_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LAG_FRAMES = 2'd2;

    localparam logic        PACING_RESET = 1'b1;
    localparam logic [31:0] INTERVAL_RESET = 32'd16683;
    localparam logic [3:0]  MAX_LAG_RESET = 4'd4;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_FRAME_DONE = 1'b1;

    localparam logic [2:0] REASON_BYPASS = 3'd0;
    localparam logic [2:0] REASON_FIRST_ARM = 3'd1;
    localparam logic [2:0] REASON_REANCHOR = 3'd2;
    localparam logic [2:0] REASON_LATE = 3'd3;
    localparam logic [2:0] REASON_WAITED = 3'd4;

    typedef struct packed {
        logic command;
        logic interp_active;
    } t_in;

    typedef struct packed {
        logic [2:0]  release_reason;
        logic [4:0]  intervals_advanced;
        logic [47:0] next_deadline;
    } t_out;

    typedef struct packed {
        logic load;
        logic tick;
        logic release_due;
        logic bypass;
        logic arm;
        logic anchor;
        logic catch_start;
        logic catch_step;
        logic catch_done;
        logic hold;
    } t_dp_cmd;

    typedef struct packed {
        logic pending;
        logic armed;
        logic due;
        logic reanchor;
        logic catch_over;
        logic drift;
    } t_dp_stat;

endpackage

>>> rtl/dfp_datapath.sv
// Datapath of the deadline frame pacer: time counter, deadline, schedule flags
// and the catch-up accumulator. Depends on dfp_pkg; driven by dfp_ctrl.
module dfp_datapath #(
    parameter int TIME_BITS = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dfp_pkg::t_dp_cmd   i_cmd,
    input  logic [31:0]        i_interval,
    input  logic [3:0]         i_max_lag,
    output dfp_pkg::t_dp_stat  o_stat,
    output logic [4:0]         o_k,
    output logic [47:0]        o_deadline
);

    localparam int AW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
    localparam int CW = ((TIME_BITS > dfp_pkg::LAG_W) ? TIME_BITS : dfp_pkg::LAG_W) + 1;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    function automatic logic [TIME_BITS-1:0] sat_sum(input logic [TIME_BITS-1:0] a,
                                                     input logic [31:0] b);
        logic [AW-1:0] s;
        s = AW'(a) + AW'(b);
        if (s > AW'(TMAX)) begin
            return TMAX;
        end
        return s[TIME_BITS-1:0];
    endfunction

    logic [TIME_BITS-1:0]     r_now;
    logic [TIME_BITS-1:0]     r_deadline;
    logic                     r_armed;
    logic                     r_pending;
    logic [31:0]              r_iv;
    logic [dfp_pkg::LAG_W-1:0] r_lag;
    logic [AW-1:0]            r_acc;
    logic [4:0]               r_k;

    logic [31:0]              eff_iv;
    logic [TIME_BITS-1:0]     now_plus_iv;
    logic [TIME_BITS-1:0]     dl_plus_iv;
    logic [TIME_BITS-1:0]     gap;
    logic [TIME_BITS+47:0]    dl_ext;

    assign eff_iv = (i_interval == 32'd0) ? 32'd1 : i_interval;
    assign now_plus_iv = sat_sum(r_now, r_iv);
    assign dl_plus_iv = sat_sum(r_deadline, r_iv);
    assign gap = r_now - r_deadline;

    assign o_stat.pending = r_pending;
    assign o_stat.armed = r_armed;
    assign o_stat.due = (r_now >= r_deadline);
    assign o_stat.reanchor = (r_now > r_deadline) && (CW'(gap) > CW'(r_lag));
    assign o_stat.catch_over = (r_acc > AW'(r_now));
    assign o_stat.drift = ((CW'(r_deadline) + CW'(r_lag)) < CW'(r_now));

    assign dl_ext = {48'd0, r_deadline};
    assign o_deadline = dl_ext[47:0];
    assign o_k = r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= '0;
            r_deadline <= '0;
            r_armed <= 1'b0;
            r_pending <= 1'b0;
        end else begin
            if (i_cmd.load && i_cmd.tick && (r_now != TMAX)) begin
                r_now <= r_now + 1'b1;
            end
            if (i_cmd.release_due) begin
                r_pending <= 1'b0;
                r_deadline <= dl_plus_iv;
            end else if (i_cmd.bypass) begin
                r_armed <= 1'b0;
                r_deadline <= '0;
            end else if (i_cmd.arm) begin
                r_armed <= 1'b1;
                r_deadline <= now_plus_iv;
            end else if (i_cmd.anchor) begin
                r_deadline <= now_plus_iv;
            end else if (i_cmd.catch_done) begin
                r_deadline <= (r_acc > AW'(TMAX)) ? TMAX : r_acc[TIME_BITS-1:0];
            end else if (i_cmd.hold) begin
                r_pending <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_iv <= eff_iv;
            r_lag <= dfp_pkg::LAG_W'(eff_iv) * dfp_pkg::LAG_W'(i_max_lag);
            r_k <= 5'd0;
        end else if (i_cmd.catch_start) begin
            r_acc <= AW'(r_deadline) + AW'(r_iv);
            r_k <= 5'd1;
        end else if (i_cmd.catch_step) begin
            r_acc <= r_acc + AW'(r_iv);
            r_k <= r_k + 5'd1;
        end
    end

endmodule

>>> rtl/dfp_ctrl.sv
// Controller of the deadline frame pacer: sequences load, evaluation, catch-up,
// drift guard and result hand-off. Depends on dfp_pkg; drives dfp_datapath.
module dfp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dfp_pkg::t_in       i_in,
    input  logic               i_pacing_enabled,
    input  logic               i_out_free,
    input  dfp_pkg::t_dp_stat  i_stat,
    output logic               o_in_ready,
    output dfp_pkg::t_dp_cmd   o_cmd,
    output logic               o_emit,
    output logic [2:0]         o_reason
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_CATCH = 3'd3;
    localparam logic [2:0] S_GUARD = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_command;
    logic       r_interp;
    logic [2:0] r_reason;
    logic [2:0] n_reason;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_reason = r_reason;

    always_comb begin
        n_state = r_state;
        n_reason = r_reason;
        o_cmd = '0;
        o_emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                o_cmd.tick = (r_command == dfp_pkg::CMD_TICK);
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (r_command == dfp_pkg::CMD_TICK) begin
                    if (i_stat.pending && i_stat.due) begin
                        o_cmd.release_due = 1'b1;
                        n_state = S_GUARD;
                    end
                end else if (i_stat.pending) begin
                    n_state = S_IDLE;
                end else if (!i_pacing_enabled || r_interp) begin
                    o_cmd.bypass = 1'b1;
                    n_reason = dfp_pkg::REASON_BYPASS;
                    n_state = S_EMIT;
                end else if (!i_stat.armed) begin
                    o_cmd.arm = 1'b1;
                    n_reason = dfp_pkg::REASON_FIRST_ARM;
                    n_state = S_EMIT;
                end else if (i_stat.reanchor) begin
                    o_cmd.anchor = 1'b1;
                    n_reason = dfp_pkg::REASON_REANCHOR;
                    n_state = S_EMIT;
                end else if (i_stat.due) begin
                    o_cmd.catch_start = 1'b1;
                    n_state = S_CATCH;
                end else begin
                    o_cmd.hold = 1'b1;
                end
            end
            S_CATCH: begin
                if (i_stat.catch_over) begin
                    o_cmd.catch_done = 1'b1;
                    n_reason = dfp_pkg::REASON_LATE;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.catch_step = 1'b1;
                end
            end
            S_GUARD: begin
                o_cmd.anchor = i_stat.drift;
                n_reason = dfp_pkg::REASON_WAITED;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reason <= n_reason;
        if (o_in_ready && i_in_valid) begin
            r_command <= i_in.command;
            r_interp <= i_in.interp_active;
        end
    end

endmodule

>>> rtl/deadline_frame_pacer.sv
// Top level of the deadline frame pacer: configuration registers, output register,
// controller and datapath. Depends on dfp_pkg, dfp_ctrl and dfp_datapath.
//
// Requests enter on the input channel (i_in_valid, o_in_ready, i_in) as either a
// tick, which advances the internal time counter by one, or a frame-done request.
// Releases leave on the output channel (o_out_valid, i_out_ready, o_out) with their
// reason, the intervals moved in a late catch-up and the new deadline.
// Registers are written through i_cfg_we, i_cfg_index and i_cfg_data.
// A request without a release passes through acceptance, load and evaluation.
// A frame-done release adds the hand-off, and a release on a tick adds the drift
// guard and the hand-off. A late catch-up adds the hand-off and one catch-up step
// per whole interval moved (up to sixteen), since the adder advances the deadline
// by one interval per cycle. While the receiver stalls, the result waits in the
// output register and the block keeps accepting requests; a later result then
// waits in the controller until the output register frees.
// Reset loads the register defaults, clears the time counter and deadline, and
// leaves the schedule unarmed with nothing waiting.
module deadline_frame_pacer #(
    parameter int TIME_BITS = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dfp_pkg::t_in                        i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dfp_pkg::t_out                       o_out,
    input  logic                                i_cfg_we,
    input  logic [dfp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dfp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic              r_pacing_enabled;
    logic [31:0]       r_interval_ticks;
    logic [3:0]        r_max_lag_frames;
    logic              r_out_valid;
    dfp_pkg::t_out     r_out;

    dfp_pkg::t_dp_cmd  dp_cmd;
    dfp_pkg::t_dp_stat dp_stat;
    logic              emit;
    logic [2:0]        reason;
    logic [4:0]        k;
    logic [47:0]       deadline;
    logic              out_free;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pacing_enabled <= dfp_pkg::PACING_RESET;
            r_interval_ticks <= dfp_pkg::INTERVAL_RESET;
            r_max_lag_frames <= dfp_pkg::MAX_LAG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dfp_pkg::REG_PACING_ENABLED: r_pacing_enabled <= i_cfg_data[0];
                dfp_pkg::REG_INTERVAL_TICKS: r_interval_ticks <= i_cfg_data[31:0];
                dfp_pkg::REG_MAX_LAG_FRAMES: r_max_lag_frames <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.release_reason <= reason;
            r_out.intervals_advanced <= k;
            r_out.next_deadline <= deadline;
        end
    end

    dfp_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in             (i_in),
        .i_pacing_enabled (r_pacing_enabled),
        .i_out_free       (out_free),
        .i_stat           (dp_stat),
        .o_in_ready       (o_in_ready),
        .o_cmd            (dp_cmd),
        .o_emit           (emit),
        .o_reason         (reason)
    );

    dfp_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_interval (r_interval_ticks),
        .i_max_lag  (r_max_lag_frames),
        .o_stat     (dp_stat),
        .o_k        (k),
        .o_deadline (deadline)
    );

    a_bypass_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.release_reason == dfp_pkg::REASON_BYPASS))
        |-> (o_out.next_deadline == 48'd0 && o_out.intervals_advanced == 5'd0))
        else $error("bypass release carries a deadline or interval count");

    a_count_only_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.release_reason != dfp_pkg::REASON_LATE))
        |-> (o_out.intervals_advanced == 5'd0))
        else $error("interval count reported outside a late catch-up");

    a_late_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.release_reason == dfp_pkg::REASON_LATE))
        |-> (o_out.intervals_advanced != 5'd0 && o_out.intervals_advanced <= 5'd16))
        else $error("late catch-up moved an impossible number of intervals");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request accepted while one is in progress");

endmodule

>>> bench/testbench.sv
// Self-checking bench for deadline_frame_pacer: a scoreboard class predicts every release
// from the accepted requests and compares it field by field with the block's output.
// Depends on dfp_pkg and the pacer RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dfp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [63:0] TICK_LIMIT = 64'hFFFF_FFFF_FFFF;

    class release_scoreboard;
        bit            pacing_on;
        bit [31:0]     interval_reg;
        bit [3:0]      lag_frames;
        logic [63:0]   now_ticks;
        logic [63:0]   deadline_at;
        bit            armed;
        bit            release_waiting;
        dfp_pkg::t_out due_releases[$];
        int            errors;
        int            requests_noted;
        int            releases_checked;
        int            reason_count[5];

        function new();
            pacing_on = dfp_pkg::PACING_RESET;
            interval_reg = dfp_pkg::INTERVAL_RESET;
            lag_frames = dfp_pkg::MAX_LAG_RESET;
            now_ticks = '0;
            deadline_at = '0;
            armed = 1'b0;
            release_waiting = 1'b0;
            errors = 0;
            requests_noted = 0;
            releases_checked = 0;
            foreach (reason_count[i]) reason_count[i] = 0;
        endfunction

        function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
            if (a > TICK_LIMIT) a = TICK_LIMIT;
            if (b > TICK_LIMIT - a) return TICK_LIMIT;
            return a + b;
        endfunction

        function logic [63:0] step_size();
            return (interval_reg == 0) ? 64'd1 : {32'd0, interval_reg};
        endfunction

        function logic [63:0] lag_span();
            return step_size() * lag_frames;
        endfunction

        function bit risky_frame();
            return armed && !release_waiting && (deadline_at > now_ticks + 64);
        endfunction

        function int outstanding();
            return due_releases.size();
        endfunction

        function void apply_write(logic [dfp_pkg::CFG_IDX_W-1:0] idx,
                                  logic [dfp_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                dfp_pkg::REG_PACING_ENABLED: pacing_on = data[0];
                dfp_pkg::REG_INTERVAL_TICKS: interval_reg = data;
                dfp_pkg::REG_MAX_LAG_FRAMES: lag_frames = data[3:0];
                default: ;
            endcase
        endfunction

        function void expect_release(logic [2:0] reason, logic [4:0] adv, logic [63:0] dl);
            dfp_pkg::t_out rel;
            rel.release_reason = reason;
            rel.intervals_advanced = adv;
            rel.next_deadline = dl[47:0];
            due_releases.push_back(rel);
            reason_count[reason]++;
        endfunction

        function void note_request(dfp_pkg::t_in req);
            logic [63:0] step;
            logic [63:0] span;
            logic [63:0] k;
            step = step_size();
            span = lag_span();
            requests_noted++;
            if (req.command == dfp_pkg::CMD_TICK) begin
                now_ticks = sat_sum(now_ticks, 64'd1);
                if (release_waiting && now_ticks >= deadline_at) begin
                    release_waiting = 1'b0;
                    deadline_at = sat_sum(deadline_at, step);
                    if (now_ticks >= span && deadline_at < now_ticks - span)
                        deadline_at = sat_sum(now_ticks, step);
                    expect_release(dfp_pkg::REASON_WAITED, 5'd0, deadline_at);
                end
            end else if (!release_waiting) begin
                if (!pacing_on || req.interp_active) begin
                    armed = 1'b0;
                    deadline_at = '0;
                    expect_release(dfp_pkg::REASON_BYPASS, 5'd0, 64'd0);
                end else if (!armed) begin
                    armed = 1'b1;
                    deadline_at = sat_sum(now_ticks, step);
                    expect_release(dfp_pkg::REASON_FIRST_ARM, 5'd0, deadline_at);
                end else if (now_ticks > deadline_at && now_ticks - deadline_at > span) begin
                    deadline_at = sat_sum(now_ticks, step);
                    expect_release(dfp_pkg::REASON_REANCHOR, 5'd0, deadline_at);
                end else if (deadline_at <= now_ticks) begin
                    k = (now_ticks - deadline_at) / step + 64'd1;
                    deadline_at = sat_sum(deadline_at, k * step);
                    expect_release(dfp_pkg::REASON_LATE, k[4:0], deadline_at);
                end else begin
                    release_waiting = 1'b1;
                end
            end
        endfunction

        function void check_release(dfp_pkg::t_out got);
            dfp_pkg::t_out want;
            releases_checked++;
            if (due_releases.size() == 0) begin
                $error("release with none expected: reason %0d, deadline %0d",
                       got.release_reason, got.next_deadline);
                errors++;
                return;
            end
            want = due_releases.pop_front();
            if (got.release_reason !== want.release_reason) begin
                $error("release_reason: expected %0d, got %0d",
                       want.release_reason, got.release_reason);
                errors++;
            end
            if (got.intervals_advanced !== want.intervals_advanced) begin
                $error("intervals_advanced: expected %0d, got %0d",
                       want.intervals_advanced, got.intervals_advanced);
                errors++;
            end
            if (got.next_deadline !== want.next_deadline) begin
                $error("next_deadline: expected %0d, got %0d",
                       want.next_deadline, got.next_deadline);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    dfp_pkg::t_in                   i_in = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    dfp_pkg::t_out                  o_out;
    logic                           i_cfg_we = 1'b0;
    logic [dfp_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [dfp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    bit                             steady = 1'b0;
    release_scoreboard              sb;

    deadline_frame_pacer DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 26);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_release(o_out);
    end

    task automatic send_request(input dfp_pkg::t_in req);
        while (!steady && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(req);
    endtask

    task automatic send_ticks(input logic [63:0] count);
        dfp_pkg::t_in req;
        repeat (count) begin
            req.command = dfp_pkg::CMD_TICK;
            req.interp_active = 1'($urandom_range(1));
            send_request(req);
        end
    endtask

    task automatic send_frame(input logic interp);
        dfp_pkg::t_in req;
        req.command = dfp_pkg::CMD_FRAME_DONE;
        req.interp_active = interp;
        send_request(req);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [dfp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [dfp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.apply_write(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input logic pace, input logic [31:0] ivl,
                             input logic [3:0] lag, input int budget);
        logic [31:0]  junk;
        logic [63:0]  far;
        logic [63:0]  span;
        logic [63:0]  step;
        logic [63:0]  slack;
        logic [63:0]  ticks;
        int           done;
        int           roll;
        dfp_pkg::t_in req;
        settle();
        junk = $urandom();
        write_register(dfp_pkg::REG_PACING_ENABLED,
                       {($urandom_range(1) != 0) ? junk[31:1] : 31'd0, pace});
        write_register(dfp_pkg::REG_INTERVAL_TICKS, ivl);
        junk = $urandom();
        write_register(dfp_pkg::REG_MAX_LAG_FRAMES,
                       {($urandom_range(1) != 0) ? junk[31:4] : 28'd0, lag});
        write_register(REG_UNUSED, $urandom());
        done = 0;
        while (done < budget) begin
            step = sb.step_size();
            span = sb.lag_span();
            far = (sb.deadline_at > sb.now_ticks) ? sb.deadline_at - sb.now_ticks : 64'd0;
            roll = $urandom_range(99);
            if (roll < 8) begin
                req.command = 1'($urandom_range(1));
                req.interp_active = 1'($urandom_range(1)) | sb.risky_frame();
                if (req.command == dfp_pkg::CMD_TICK || !sb.release_waiting) done++;
                send_request(req);
            end else begin
                if (sb.release_waiting) begin
                    slack = span + step;
                    if (slack > 64'd40) slack = 64'd40;
                    ticks = far + 64'($urandom_range(32'(slack)));
                end else if (!sb.armed || far == 0 || far + span > 400) begin
                    ticks = 64'($urandom_range(2));
                end else begin
                    roll = $urandom_range(99);
                    if (roll < 30)
                        ticks = 64'($urandom_range(32'(far - 1)));
                    else if (roll < 75)
                        ticks = far + (($urandom_range(3) == 0) ? span
                                                               : 64'($urandom_range(32'(span))));
                    else
                        ticks = far + span + 64'd1 + 64'($urandom_range(32'(step)));
                end
                send_ticks(ticks);
                done += int'(ticks) + 1;
                send_frame(($urandom_range(99) < 6) || sb.risky_frame());
                if (sb.release_waiting && $urandom_range(2) == 0)
                    send_frame(1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(1'b0);
        send_frame(1'b1);
        settle();
        write_register(dfp_pkg::REG_INTERVAL_TICKS, 32'd2);
        write_register(dfp_pkg::REG_MAX_LAG_FRAMES, 32'd1);
        write_register(dfp_pkg::REG_PACING_ENABLED, 32'd1);
        send_frame(1'b0);
        send_frame(1'b0);
        send_frame(1'b0);
        send_ticks(2);
        send_ticks(3);
        send_frame(1'b0);
        send_ticks(3);
        send_frame(1'b0);
        send_ticks(5);
        send_frame(1'b0);
        send_frame(1'b0);
        settle();
        write_register(dfp_pkg::REG_INTERVAL_TICKS, 32'd5);
        send_ticks(2);
        settle();
        write_register(dfp_pkg::REG_PACING_ENABLED, 32'hFFFF_FFFE);
        write_register(REG_UNUSED, 32'hFFFF_FFFF);
        send_frame(1'b0);

        run_phase(1'b1, 32'd4, 4'd3, 200);
        run_phase(1'b1, 32'd1, 4'd15, 220);
        run_phase(1'b1, 32'd0, 4'd2, 150);
        run_phase(1'b1, 32'd7, 4'd0, 180);
        run_phase(1'b0, 32'd5, 4'd4, 100);
        run_phase(1'b1, 32'hFFFF_FFFF, 4'd15, 80);
        run_phase(1'b1, 32'd12, 4'd1, 200);
        steady = 1'b1;
        run_phase(1'b1, 32'd2, 4'd8, 250);
        steady = 1'b0;
        repeat (2)
            run_phase($urandom_range(99) < 85, $urandom_range(9, 1),
                      4'($urandom_range(15)), 250);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Run covered %0d requests and %0d releases over an opening sequence and %s",
                 sb.requests_noted, sb.releases_checked, "ten register phases.");
        $display("Releases by reason: bypass %0d, first arm %0d, re-anchor %0d, %s %0d, %s %0d.",
                 sb.reason_count[dfp_pkg::REASON_BYPASS],
                 sb.reason_count[dfp_pkg::REASON_FIRST_ARM],
                 sb.reason_count[dfp_pkg::REASON_REANCHOR],
                 "late", sb.reason_count[dfp_pkg::REASON_LATE],
                 "waited", sb.reason_count[dfp_pkg::REASON_WAITED]);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

>>> files.f
rtl/dfp_pkg.sv
rtl/dfp_datapath.sv
rtl/dfp_ctrl.sv
rtl/deadline_frame_pacer.sv
bench/testbench.sv
